// ----- hdl/ple_pkg.sv -----
package ple_pkg;

    // Command codes carried in the input transaction
    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_PREPEND   = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_DUMP      = 3'd3,
        CMD_UPDATE    = 3'd4,
        CMD_DEL_FRONT = 3'd5,
        CMD_DEL_END   = 3'd6,
        CMD_DEL_POS   = 3'd7
    } t_cmd;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] element;
        logic               last;
    } t_out;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_INS,
        S_INS_WR,
        S_DEL,
        S_DEL_WR,
        S_DMP_RD,
        S_DMP_OUT,
        S_FIN
    } t_state;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_LOAD,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RA_IDX,
        RA_IDX_M1,
        RA_IDX_P1
    } t_rsel;

    typedef enum logic {
        W_SHIFT,
        W_VALUE
    } t_wsel;

    typedef enum logic {
        O_STATUS,
        O_DUMP
    } t_osel;

    // Commands from controller to datapath
    typedef struct packed {
        logic    ld;
        logic    st_ld;
        t_idx_op idx_op;
        logic    rd_en;
        t_rsel   rd_sel;
        logic    wr_en;
        t_wsel   wr_sel;
        t_cnt_op cnt_op;
        logic    out_ld;
        t_osel   out_sel;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        t_cmd    cmd;
        t_status chk;
        logic    at_tgt;
        logic    shift_done;
        logic    dump_last;
        logic    out_free;
    } t_sts;

endpackage

// ----- hdl/ple_ctrl.sv -----
module ple_ctrl
    import ple_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  t_sts   i_sts,
    output t_ctl   o_ctl,
    output logic   o_ready,
    output t_state o_state
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.chk != ST_OK) begin
                    n_state = S_FIN;
                end else begin
                    case (i_sts.cmd)
                        CMD_APPEND, CMD_PREPEND, CMD_INS_POS: n_state = S_INS;
                        CMD_DUMP:                             n_state = S_DMP_RD;
                        CMD_DEL_FRONT, CMD_DEL_POS:           n_state = S_DEL;
                        default:                              n_state = S_FIN;
                    endcase
                end
            end
            S_INS:     n_state = i_sts.at_tgt ? S_FIN : S_INS_WR;
            S_INS_WR:  n_state = S_INS;
            S_DEL:     n_state = i_sts.shift_done ? S_FIN : S_DEL_WR;
            S_DEL_WR:  n_state = S_DEL;
            S_DMP_RD:  n_state = S_DMP_OUT;
            S_DMP_OUT: begin
                if (i_sts.out_free) n_state = i_sts.dump_last ? S_IDLE : S_DMP_RD;
            end
            S_FIN: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_ctl   = '{ld: 1'b0, st_ld: 1'b0, idx_op: IDX_HOLD, rd_en: 1'b0, rd_sel: RA_IDX,
                    wr_en: 1'b0, wr_sel: W_SHIFT, cnt_op: CNT_HOLD, out_ld: 1'b0,
                    out_sel: O_STATUS};
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready  = 1'b1;
                o_ctl.ld = i_in_valid;
            end
            S_EVAL: begin
                o_ctl.st_ld = 1'b1;
                if (i_sts.chk == ST_OK) begin
                    case (i_sts.cmd)
                        CMD_UPDATE: begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.wr_sel = W_VALUE;
                        end
                        CMD_DEL_END: o_ctl.cnt_op = CNT_DEC;
                        default:     o_ctl.idx_op = IDX_LOAD;
                    endcase
                end
            end
            S_INS: begin
                if (i_sts.at_tgt) begin
                    o_ctl.wr_en  = 1'b1;
                    o_ctl.wr_sel = W_VALUE;
                    o_ctl.cnt_op = CNT_INC;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RA_IDX_M1;
                end
            end
            S_INS_WR: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.idx_op = IDX_DEC;
            end
            S_DEL: begin
                if (i_sts.shift_done) begin
                    o_ctl.cnt_op = CNT_DEC;
                end else begin
                    o_ctl.rd_en  = 1'b1;
                    o_ctl.rd_sel = RA_IDX_P1;
                end
            end
            S_DEL_WR: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.idx_op = IDX_INC;
            end
            S_DMP_RD: o_ctl.rd_en = 1'b1;
            S_DMP_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_ld  = 1'b1;
                    o_ctl.out_sel = O_DUMP;
                    o_ctl.idx_op  = IDX_INC;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) o_ctl.out_ld = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_state = r_state;

endmodule

// ----- hdl/ple_dp.sv -----
module ple_dp
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  t_ctl i_ctl,
    input  logic i_out_stall,
    output t_sts o_sts,
    output logic o_out_valid,
    output t_out o_out
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [31:0]        r_mem [CAPACITY];
    logic signed [31:0] r_rd;
    t_cmd               r_cmd;
    logic [7:0]         r_pos;
    logic signed [31:0] r_val;
    t_status            r_st;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      n_idx;
    logic               r_out_valid;
    t_out               r_out;

    logic [7:0]    pos_m1;
    logic [CW-1:0] tgt;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_m1;
    logic [8:0]    pos9;
    logic [8:0]    cnt9;
    logic          full;
    logic          empty;
    logic          bad_ins;
    logic          bad_pos;
    t_status       chk;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          out_free;

    // Latched command
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_cmd <= i_in.cmd;
            r_pos <= i_in.position;
            r_val <= i_in.value;
        end
        if (i_ctl.st_ld) r_st <= chk;
    end

    // Position and occupancy checks
    assign pos_m1  = r_pos - 8'd1;
    assign idx_p1  = r_idx + CW'(1);
    assign idx_m1  = r_idx - CW'(1);
    assign pos9    = {1'b0, r_pos};
    assign cnt9    = 9'(r_cnt);
    assign full    = (r_cnt == CW'(CAPACITY));
    assign empty   = (r_cnt == '0);
    assign bad_ins = (r_pos == 8'd0) || (pos9 > cnt9 + 9'd1);
    assign bad_pos = (r_pos == 8'd0) || (pos9 > cnt9);

    always_comb begin
        case (r_cmd)
            CMD_APPEND, CMD_PREPEND: chk = full ? ST_FULL : ST_OK;
            CMD_INS_POS:             chk = full ? ST_FULL : (bad_ins ? ST_BADPOS : ST_OK);
            CMD_DUMP, CMD_DEL_FRONT,
            CMD_DEL_END:             chk = empty ? ST_EMPTY : ST_OK;
            default:                 chk = bad_pos ? ST_BADPOS : ST_OK;
        endcase
    end

    // Zero-based slot the command works on
    always_comb begin
        case (r_cmd)
            CMD_APPEND:               tgt = r_cnt;
            CMD_PREPEND, CMD_DEL_FRONT: tgt = '0;
            default:                  tgt = pos_m1[CW-1:0];
        endcase
    end

    // Walking index
    always_comb begin
        case (i_ctl.idx_op)
            IDX_LOAD: begin
                case (r_cmd)
                    CMD_APPEND, CMD_PREPEND, CMD_INS_POS: n_idx = r_cnt;
                    CMD_DEL_FRONT, CMD_DEL_POS:           n_idx = tgt;
                    default:                              n_idx = '0;
                endcase
            end
            IDX_INC: n_idx = idx_p1;
            IDX_DEC: n_idx = idx_m1;
            default: n_idx = r_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

    // Element count
    always_comb begin
        case (i_ctl.cnt_op)
            CNT_INC: n_cnt = r_cnt + CW'(1);
            CNT_DEC: n_cnt = r_cnt - CW'(1);
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Element memory, one read and one write port
    always_comb begin
        case (i_ctl.rd_sel)
            RA_IDX_M1: rd_addr = idx_m1[IW-1:0];
            RA_IDX_P1: rd_addr = idx_p1[IW-1:0];
            default:   rd_addr = r_idx[IW-1:0];
        endcase
    end

    assign wr_addr = (i_ctl.wr_sel == W_VALUE) ? tgt[IW-1:0] : r_idx[IW-1:0];
    assign wr_data = (i_ctl.wr_sel == W_VALUE) ? r_val : r_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) r_mem[wr_addr] <= wr_data;
        if (i_ctl.rd_en) r_rd <= $signed(r_mem[rd_addr]);
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_ld) begin
            if (i_ctl.out_sel == O_DUMP) begin
                r_out <= '{status: ST_OK, element: r_rd, last: (idx_p1 == r_cnt)};
            end else begin
                r_out <= '{status: r_st, element: 32'sd0, last: 1'b1};
            end
        end
    end

    assign o_sts = '{cmd: r_cmd, chk: chk, at_tgt: (r_idx == tgt),
                     shift_done: ({1'b0, idx_p1} >= {1'b0, r_cnt}),
                     dump_last: (idx_p1 == r_cnt), out_free: out_free};
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- hdl/positional_list_engine.sv -----
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// values, addressed by 1-based position.
// Input channel: i_in_valid / o_in_stall carry one command transaction
// (cmd, position, value). Output channel: o_out_valid / i_out_stall carry
// result transactions (status, element, last).
// Each command gives one status result, except a dump of a non-empty list,
// which gives one result per element in order, with last set on the final one.
// One command is handled at a time; o_in_stall is low only while idle, so the
// next command is taken in the cycle after the last result of the previous one.
// A status-only command is evaluated, then its result is loaded from the finish
// state. An insert or delete shifts the list tail one element at a time, each
// by a memory read and then a write back. A dump reads each element and then
// loads it into the output register, one element after the other.
// A finished result waits in the output register; a new command is taken
// while it waits, and the engine only pauses when it must emit the next
// result into an occupied, stalled output register.
// Reset clears the element count and the output valid; stored values are
// left as they were and are never read before being written.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    t_ctl   ctl;
    t_sts   sts;
    t_state state;
    logic   ready;

    ple_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_ready    (ready),
        .o_state    (state)
    );

    ple_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign o_in_stall = !ready;

`ifndef SYNTHESIS
    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_ld |-> sts.out_free)
        else $error("result loaded into a stalled output register");

    // The element store is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == S_IDLE) |-> !ctl.wr_en)
        else $error("memory write while idle");

    // An accepted transaction closes the input until it is done
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a command is in progress");
`endif

endmodule

// ----- verif/positional_list_engine_tb.sv -----
`timescale 1ns / 1ps

module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int LIST_DEPTH = 32;

    // Command mixes for the random phases
    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_ANY
    } t_mix;

    logic i_clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_data;
    logic out_valid;
    logic out_stall;
    t_out out_data;
    bit   calm;

    // Shadow of the list contents and the results it must produce
    class list_mirror;
        logic signed [31:0] entries[$];
        t_out               pending_results[$];
        int                 fails;
        int                 commands;
        int                 results;
        int                 peak;
        int                 full_refusals;

        function void push_status(t_status st);
            t_out res;
            res.status  = st;
            res.element = '0;
            res.last    = 1'b1;
            pending_results.push_back(res);
            if (st == ST_FULL) full_refusals++;
        endfunction

        function void note_command(t_in item);
            int unsigned pos;
            int unsigned len;
            t_out        res;
            pos = 32'(item.position);
            len = entries.size();
            commands++;
            case (item.cmd)
                CMD_APPEND, CMD_PREPEND, CMD_INS_POS: begin
                    // full check ranks above the position check
                    if (len >= LIST_DEPTH) begin
                        push_status(ST_FULL);
                    end else if (item.cmd == CMD_APPEND) begin
                        entries.push_back(item.value);
                        push_status(ST_OK);
                    end else if (item.cmd == CMD_PREPEND) begin
                        entries.push_front(item.value);
                        push_status(ST_OK);
                    end else if (pos == 0 || pos > len + 1) begin
                        push_status(ST_BADPOS);
                    end else begin
                        entries.insert(pos - 1, item.value);
                        push_status(ST_OK);
                    end
                end
                CMD_DUMP: begin
                    if (len == 0) begin
                        push_status(ST_EMPTY);
                    end else begin
                        for (int i = 0; i < len; i++) begin
                            res.status  = ST_OK;
                            res.element = entries[i];
                            res.last    = (i == len - 1);
                            pending_results.push_back(res);
                        end
                    end
                end
                CMD_UPDATE: begin
                    if (pos == 0 || pos > len) begin
                        push_status(ST_BADPOS);
                    end else begin
                        entries[pos - 1] = item.value;
                        push_status(ST_OK);
                    end
                end
                CMD_DEL_FRONT: begin
                    if (len == 0) begin
                        push_status(ST_EMPTY);
                    end else begin
                        void'(entries.pop_front());
                        push_status(ST_OK);
                    end
                end
                CMD_DEL_END: begin
                    if (len == 0) begin
                        push_status(ST_EMPTY);
                    end else begin
                        void'(entries.pop_back());
                        push_status(ST_OK);
                    end
                end
                default: begin
                    // delete at a position; an empty list lands here as a bad position
                    if (pos == 0 || pos > len) begin
                        push_status(ST_BADPOS);
                    end else begin
                        entries.delete(pos - 1);
                        push_status(ST_OK);
                    end
                end
            endcase
            if (entries.size() > peak) peak = entries.size();
        endfunction

        function void check_result(t_out got);
            t_out want;
            results++;
            if (pending_results.size() == 0) begin
                $error("result with nothing outstanding: status %0d element %0d last %0b",
                       got.status, got.element, got.last);
                fails++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fails++;
            end
            if (got.element !== want.element) begin
                $error("element: expected %0d, got %0d", want.element, got.element);
                fails++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                fails++;
            end
        endfunction
    endclass

    list_mirror mirror;

    positional_list_engine #(
        .CAPACITY(LIST_DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_data)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watch both channels on the rising edge
    always @(posedge i_clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) mirror.note_command(in_data);
            if (out_valid && !out_stall) mirror.check_result(out_data);
        end
    end

    // Result side back-pressure in bursts
    initial begin
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns once the command transaction is taken
    task automatic drive_command(input t_in item);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic issue(input t_cmd op, input logic [7:0] pos, input logic signed [31:0] v);
        t_in item;
        item.cmd      = op;
        item.position = pos;
        item.value    = v;
        @(negedge i_clk);
        drive_command(item);
    endtask

    // Mostly well-formed positions against the current length, some noise
    function automatic t_in random_command(input t_mix mix);
        t_in         item;
        int unsigned len;
        int unsigned roll;
        int unsigned sel;
        len  = mirror.entries.size();
        roll = $urandom_range(0, 99);
        sel  = $urandom_range(0, 2);
        item.value = $urandom;
        case (mix)
            MIX_GROW: begin
                if (roll < 75)      item.cmd = t_cmd'(sel);
                else if (roll < 83) item.cmd = CMD_UPDATE;
                else if (roll < 90) item.cmd = CMD_DUMP;
                else                item.cmd = t_cmd'(CMD_DEL_FRONT + sel);
            end
            MIX_SHRINK: begin
                if (roll < 65)      item.cmd = t_cmd'(CMD_DEL_FRONT + sel);
                else if (roll < 75) item.cmd = CMD_UPDATE;
                else if (roll < 83) item.cmd = CMD_DUMP;
                else                item.cmd = t_cmd'(sel);
            end
            default: item.cmd = t_cmd'($urandom_range(0, 7));
        endcase
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            item.position = 8'($urandom_range(0, 255));
        end else if (item.cmd == CMD_APPEND || item.cmd == CMD_PREPEND
                     || item.cmd == CMD_INS_POS) begin
            if (roll == 1) item.position = $urandom_range(0, 1) ? 8'(len + 2) : 8'd0;
            else           item.position = 8'($urandom_range(1, len + 1));
        end else begin
            if (roll == 1)     item.position = $urandom_range(0, 1) ? 8'(len + 1) : 8'd0;
            else if (len == 0) item.position = 8'd1;
            else               item.position = 8'($urandom_range(1, len));
        end
        return item;
    endfunction

    task automatic random_phase(input t_mix mix, input int n);
        t_in item;
        for (int i = 0; i < n; i++) begin
            @(negedge i_clk);
            item = random_command(mix);
            drive_command(item);
        end
    endtask

    // Main sequence
    initial begin
        mirror   = new();
        calm     = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // empty list corners
        issue(CMD_DUMP, 8'd0, 32'sd0);
        issue(CMD_DEL_FRONT, 8'd1, 32'sd0);
        issue(CMD_DEL_END, 8'd1, 32'sd0);
        issue(CMD_DEL_POS, 8'd1, 32'sd0);
        issue(CMD_UPDATE, 8'd1, 32'sd5);
        issue(CMD_INS_POS, 8'd0, 32'sd7);
        issue(CMD_INS_POS, 8'd2, 32'sd7);
        // build a short list with extreme values, including insert at count+1
        issue(CMD_INS_POS, 8'd1, 32'sh8000_0000);
        issue(CMD_APPEND, 8'd0, 32'sh7fff_ffff);
        issue(CMD_PREPEND, 8'd0, -32'sd1);
        issue(CMD_INS_POS, 8'd4, 32'sd0);
        issue(CMD_INS_POS, 8'd2, 32'sd1);
        // update range edges
        issue(CMD_UPDATE, 8'd255, 32'sd9);
        issue(CMD_UPDATE, 8'd6, 32'sd9);
        issue(CMD_UPDATE, 8'd5, 32'sh5555_5555);
        issue(CMD_UPDATE, 8'd1, 32'shaaaa_aaaa);
        issue(CMD_DUMP, 8'd0, 32'sd0);
        // deletes: out of range, middle, tail, both ends
        issue(CMD_DEL_POS, 8'd6, 32'sd0);
        issue(CMD_DEL_POS, 8'd0, 32'sd0);
        issue(CMD_DEL_POS, 8'd3, 32'sd0);
        issue(CMD_DEL_POS, 8'd4, 32'sd0);
        issue(CMD_DEL_FRONT, 8'd0, 32'sd0);
        issue(CMD_DEL_END, 8'd0, 32'sd0);
        issue(CMD_DUMP, 8'd0, 32'sd0);
        issue(CMD_DEL_POS, 8'd1, 32'sd0);

        // random: fill towards full, drain, churn, refill with no idling at the tail
        random_phase(MIX_GROW, 60);
        random_phase(MIX_SHRINK, 50);
        random_phase(MIX_ANY, 20);
        random_phase(MIX_GROW, 15);
        calm = 1'b1;
        random_phase(MIX_GROW, 30);
        @(negedge i_clk);
        in_valid <= 1'b0;

        while (mirror.pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * LIST_DEPTH + 8) @(posedge i_clk);

        $display("Covered %0d commands and %0d results; list peaked at %0d entries.",
                 mirror.commands, mirror.results, mirror.peak);
        $display("Inserts refused on a full list: %0d.", mirror.full_refusals);
        if (mirror.fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Hang guard, well past the slowest legal run
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ple_pkg.sv
hdl/ple_ctrl.sv
hdl/ple_dp.sv
hdl/positional_list_engine.sv
verif/positional_list_engine_tb.sv
